// ===== design/conv2x2_pkg.sv =====
package conv2x2_pkg;

	// default sizes of the stores
	localparam int DEF_MAX_HEIGHT = 32;
	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_IN_CH  = 16;
	localparam int DEF_MAX_OUT_CH = 16;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int BIAS_W   = 32;
	localparam int RES_W    = 40;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_CH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN = 3'd4;

	localparam logic [5:0] RST_HEIGHT  = 6'd32;
	localparam logic [5:0] RST_WIDTH   = 6'd32;
	localparam logic [4:0] RST_IN_CH   = 5'd16;
	localparam logic [4:0] RST_OUT_CH  = 5'd16;
	localparam logic       RST_BIAS_EN = 1'b1;

	typedef enum logic [1:0] {
		FUNC_WEIGHT  = 2'd0,
		FUNC_BIAS    = 2'd1,
		FUNC_SAMPLE  = 2'd2,
		FUNC_COMPUTE = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [3:0]         channel;
		logic [3:0]         in_channel;
		logic [1:0]         tap;
		logic [4:0]         row;
		logic [4:0]         col;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] conv_result;
		logic                    status;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic wr_weight;
		logic wr_bias;
		logic wr_sample;
		logic init_acc;
		logic issue;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic item_ok;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

// ===== design/conv2x2_ctrl.sv =====
module conv2x2_ctrl import conv2x2_pkg::*; #(
	parameter int MAX_IN_CH = DEF_MAX_IN_CH,
	localparam int NICW = $clog2(MAX_IN_CH + 1),
	localparam int CW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  func_t           func,
	output logic            item_ready,
	input  logic [NICW-1:0] nic,
	input  sts_t            sts,
	output cmd_t            cmd,
	output logic [CW-1:0]   ic
);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          last_ch;

	// state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign ic      = cnt_q;
	assign last_ch = (32'(cnt_q) + 32'd1) >= 32'(nic);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (func)
						FUNC_WEIGHT: cmd.wr_weight = sts.item_ok;
						FUNC_BIAS:   cmd.wr_bias   = sts.item_ok;
						FUNC_SAMPLE: cmd.wr_sample = sts.item_ok;
						FUNC_COMPUTE: begin
							cmd.start = 1'b1;
							cnt_d     = '0;
							state_d   = sts.item_ok ? ST_RUN : ST_DONE;
						end
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue    = 32'(cnt_q) < 32'(nic);
				cmd.init_acc = (cnt_q == '0);
				cnt_d        = cnt_q + 1'b1;
				if (last_ch) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// the pipeline is empty whenever a new transaction may enter
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.pipe_busy)
		else $error("pipeline busy while idle");

	// a result is only taken from a drained pipeline
	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.pipe_busy)
		else $error("result loaded before pipeline drained");

	// an issued read shows up in the pipeline
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> sts.pipe_busy)
		else $error("issued read lost");

endmodule

// ===== design/conv2x2_dp.sv =====
module conv2x2_dp import conv2x2_pkg::*; #(
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
	parameter int MAX_OUT_CH = DEF_MAX_OUT_CH,
	localparam int HW   = $clog2(MAX_HEIGHT + 1),
	localparam int WW   = $clog2(MAX_WIDTH + 1),
	localparam int NICW = $clog2(MAX_IN_CH + 1),
	localparam int NOCW = $clog2(MAX_OUT_CH + 1),
	localparam int CW   = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  item_t           item,
	input  cmd_t            cmd,
	input  logic [CW-1:0]   ic,
	input  logic [HW-1:0]   h,
	input  logic [WW-1:0]   w,
	input  logic [NICW-1:0] nic,
	input  logic [NOCW-1:0] noc,
	input  logic            bias_en,
	output sts_t            sts,
	output result_t         result,
	output logic            result_valid,
	input  logic            result_ready
);

	// four feature banks split by row and column parity
	localparam int HB       = (MAX_HEIGHT + 1) / 2;
	localparam int WB       = (MAX_WIDTH + 1) / 2;
	localparam int FB_DEPTH = MAX_IN_CH * HB * WB;
	localparam int FA_W     = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
	localparam int WT_DEPTH = MAX_OUT_CH * MAX_IN_CH;
	localparam int WA_W     = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;
	localparam int BI_W     = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int ACC_RAW  = SUM_W + $clog2(MAX_IN_CH + 1) + 1;
	localparam int ACC_W    = (ACC_RAW > RES_W) ? ACC_RAW : RES_W + 1;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [31:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

	logic                        ch_lt_noc, ch_lt_nic, ich_lt_nic, row_lt_h, col_lt_w;
	logic [31:0]                 swr_full, wwr_full, wrd_full;
	logic signed [SAMPLE_W-1:0]  wr_val;
	logic [3:0]                  mask_d;
	logic [3:0]                  mask_q;
	logic [3:0]                  oc_q;
	logic [4:0]                  row_q, col_q;
	logic                        bad_q;
	logic signed [BIAS_W-1:0]    bias_mem [MAX_OUT_CH];
	logic signed [BIAS_W-1:0]    bias_q;
	logic signed [SAMPLE_W-1:0]  feat_s1 [4];
	logic signed [SAMPLE_W-1:0]  wgt_s1 [4];
	logic signed [SAMPLE_W-1:0]  tap_feat [4];
	logic signed [PROD_W-1:0]    prod_s2 [4];
	logic signed [SUM_W-1:0]     sum_s3;
	logic                        v_s1, v_s2, v_s3;
	logic signed [ACC_W-1:0]     acc_q;
	logic [ACC_W-RES_W:0]        top_bits;
	logic                        ovf;
	logic signed [RES_W-1:0]     res_val;
	result_t                     result_q;
	logic                        result_valid_q;

	// range checks on the incoming transaction
	assign ch_lt_noc  = 32'(item.channel) < 32'(noc);
	assign ch_lt_nic  = 32'(item.channel) < 32'(nic);
	assign ich_lt_nic = 32'(item.in_channel) < 32'(nic);
	assign row_lt_h   = 32'(item.row) < 32'(h);
	assign col_lt_w   = 32'(item.col) < 32'(w);

	always_comb begin
		unique case (item.func)
			FUNC_WEIGHT:  sts.item_ok = ch_lt_noc && ich_lt_nic;
			FUNC_BIAS:    sts.item_ok = ch_lt_noc;
			FUNC_SAMPLE:  sts.item_ok = ch_lt_nic && row_lt_h && col_lt_w;
			FUNC_COMPUTE: sts.item_ok = ch_lt_noc && row_lt_h && col_lt_w;
		endcase
	end

	// taps past the bottom or right edge are dropped
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			mask_d[k] = ((32'(item.row) + 32'(k / 2)) < 32'(h)) &&
				((32'(item.col) + 32'(k % 2)) < 32'(w));
		end
	end

	assign wr_val   = sat16(item.value);
	assign swr_full = (32'(item.channel) * 32'(HB) + 32'(item.row >> 1)) * 32'(WB) +
		32'(item.col >> 1);
	assign wwr_full = 32'(item.channel) * 32'(MAX_IN_CH) + 32'(item.in_channel);
	assign wrd_full = 32'(oc_q) * 32'(MAX_IN_CH) + 32'(ic);

	// latch the compute transaction
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			oc_q   <= item.channel;
			row_q  <= item.row;
			col_q  <= item.col;
			mask_q <= mask_d;
			bad_q  <= !sts.item_ok;
			bias_q <= bias_mem[BI_W'(item.channel)];
		end
	end

	// bias store
	always_ff @(posedge clk) begin
		if (cmd.wr_bias) begin
			bias_mem[BI_W'(item.channel)] <= item.value;
		end
	end

	// feature banks, one read per bank and channel
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam int PR = b / 2;
		localparam int PC = b % 2;
		logic signed [SAMPLE_W-1:0] mem [FB_DEPTH];
		logic [31:0]                rrow, rcol, rd_full;
		logic                       wr_en;

		assign rrow    = (32'(row_q) + 32'(1'(PR) ^ row_q[0])) >> 1;
		assign rcol    = (32'(col_q) + 32'(1'(PC) ^ col_q[0])) >> 1;
		assign rd_full = (32'(ic) * 32'(HB) + rrow) * 32'(WB) + rcol;
		assign wr_en   = cmd.wr_sample && (item.row[0] == 1'(PR)) && (item.col[0] == 1'(PC));

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[swr_full[FA_W-1:0]] <= wr_val;
			end
			if (cmd.issue) begin
				feat_s1[b] <= mem[rd_full[FA_W-1:0]];
			end
		end
	end

	// weight store, one lane per tap
	for (genvar t = 0; t < 4; t++) begin : g_lane
		logic signed [SAMPLE_W-1:0] mem [WT_DEPTH];

		always_ff @(posedge clk) begin
			if (cmd.wr_weight && (item.tap == 2'(t))) begin
				mem[wwr_full[WA_W-1:0]] <= wr_val;
			end
			if (cmd.issue) begin
				wgt_s1[t] <= mem[wrd_full[WA_W-1:0]];
			end
		end
	end

	// bank to tap reorder
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tap_feat[k] = feat_s1[2'(k) ^ {row_q[0], col_q[0]}];
		end
	end

	// four products, then their sum
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= mask_q[k] ? PROD_W'(tap_feat[k] * wgt_s1[k]) : '0;
		end
		sum_s3 <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1]) +
			SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]);
	end

	// pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;

	// accumulator
	always_ff @(posedge clk) begin
		if (cmd.init_acc) begin
			acc_q <= bias_en ? ACC_W'(bias_q) : '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(sum_s3);
		end
	end

	// saturate to the result width
	assign top_bits = acc_q[ACC_W-1:RES_W-1];
	assign ovf      = !((&top_bits) || !(|top_bits));
	assign res_val  = ovf ? (acc_q[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} :
		{1'b0, {(RES_W-1){1'b1}}}) : acc_q[RES_W-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.conv_result <= bad_q ? '0 : res_val;
			result_q.status      <= bad_q;
		end
	end

	assign sts.out_free = !result_valid_q || result_ready;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	// accumulator start never collides with a product sum
	a_init_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_acc |-> !v_s3)
		else $error("accumulator init while products pending");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(result_valid_q && !result_ready))
		else $error("result overwritten");

	// an out-of-range compute reads nothing
	a_bad_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !bad_q)
		else $error("reads issued for out-of-range compute");

endmodule

// ===== design/conv2x2_same_end_pad.sv =====
// 2x2 convolution, stride 1, same-size output with one row and one column of
// zero padding at the bottom and right. Transactions write weights (Q4.12),
// biases (Q.20) and samples (Q8.8) into on-chip stores, or ask for one output
// element, which comes back as a 40-bit saturated Q.20 value with a status bit
// (1 when the channel or pixel is outside the configured image). A compute
// walks the input channels one per cycle, reading all four taps at once from
// four feature banks split by row and column parity, then drains a three-stage
// multiply and add pipeline; an out-of-range compute skips both steps and goes
// straight to the result register.
// Writes are accepted while a result still waits to be taken.
// Stores are not cleared at reset; read only entries that have been written.
// Write configuration registers only while no compute is in flight.
module conv2x2_same_end_pad import conv2x2_pkg::*; #(
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_IN_CH  = DEF_MAX_IN_CH,
	parameter int MAX_OUT_CH = DEF_MAX_OUT_CH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int NICW = $clog2(MAX_IN_CH + 1);
	localparam int NOCW = $clog2(MAX_OUT_CH + 1);
	localparam int CW   = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;

	logic [5:0]      height_q, width_q;
	logic [4:0]      in_ch_q, out_ch_q;
	logic            bias_en_q;
	logic [31:0]     h_full, w_full, nic_full, noc_full;
	logic [HW-1:0]   h_eff;
	logic [WW-1:0]   w_eff;
	logic [NICW-1:0] nic_eff;
	logic [NOCW-1:0] noc_eff;
	cmd_t            cmd;
	sts_t            sts;
	logic [CW-1:0]   ic;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q  <= RST_HEIGHT;
			width_q   <= RST_WIDTH;
			in_ch_q   <= RST_IN_CH;
			out_ch_q  <= RST_OUT_CH;
			bias_en_q <= RST_BIAS_EN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEIGHT:  height_q  <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data;
				REG_IN_CH:   in_ch_q   <= cfg_data[4:0];
				REG_OUT_CH:  out_ch_q  <= cfg_data[4:0];
				REG_BIAS_EN: bias_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// limit the sizes to what the stores hold
	assign h_full   = (32'(height_q) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(height_q);
	assign w_full   = (32'(width_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_q);
	assign nic_full = (32'(in_ch_q) > 32'(MAX_IN_CH)) ? 32'(MAX_IN_CH) : 32'(in_ch_q);
	assign noc_full = (32'(out_ch_q) > 32'(MAX_OUT_CH)) ? 32'(MAX_OUT_CH) : 32'(out_ch_q);
	assign h_eff    = h_full[HW-1:0];
	assign w_eff    = w_full[WW-1:0];
	assign nic_eff  = nic_full[NICW-1:0];
	assign noc_eff  = noc_full[NOCW-1:0];

	conv2x2_ctrl #(
		.MAX_IN_CH (MAX_IN_CH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.func       (item.func),
		.item_ready (item_ready),
		.nic        (nic_eff),
		.sts        (sts),
		.cmd        (cmd),
		.ic         (ic)
	);

	conv2x2_dp #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_IN_CH  (MAX_IN_CH),
		.MAX_OUT_CH (MAX_OUT_CH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.ic           (ic),
		.h            (h_eff),
		.w            (w_eff),
		.nic          (nic_eff),
		.noc          (noc_eff),
		.bias_en      (bias_en_q),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

// ===== tb/sv/conv2x2_same_end_pad_test.sv =====
`timescale 1ns / 100ps

module conv2x2_same_end_pad_test;
	import conv2x2_pkg::*;

	localparam int FEAT_DEPTH    = DEF_MAX_IN_CH * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
	localparam int WGT_DEPTH     = DEF_MAX_OUT_CH * DEF_MAX_IN_CH * 4;
	localparam int SETTLE_CYCLES = DEF_MAX_IN_CH + 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int TIMEOUT_NS    = 10_000_000;
	localparam longint RES_HI    = 64'sd549755813887;
	localparam longint RES_LO    = -64'sd549755813888;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item_bus     = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result_bus;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// shadow of the configuration registers
	logic [5:0] img_rows   = RST_HEIGHT;
	logic [5:0] img_cols   = RST_WIDTH;
	logic [4:0] in_planes  = RST_IN_CH;
	logic [4:0] out_planes = RST_OUT_CH;
	logic       bias_on    = RST_BIAS_EN;
	int eff_rows = DEF_MAX_HEIGHT;
	int eff_cols = DEF_MAX_WIDTH;
	int eff_in   = DEF_MAX_IN_CH;
	int eff_out  = DEF_MAX_OUT_CH;

	// shadow stores with written flags
	logic signed [SAMPLE_W-1:0] sample_mem [FEAT_DEPTH];
	bit                         sample_set [FEAT_DEPTH];
	logic signed [SAMPLE_W-1:0] weight_mem [WGT_DEPTH];
	bit                         weight_set [WGT_DEPTH];
	logic signed [BIAS_W-1:0]   bias_mem [DEF_MAX_OUT_CH];
	bit                         bias_set [DEF_MAX_OUT_CH];

	result_t expected_elements [$];
	result_t exp_element;
	int      mismatch_count = 0;
	int      burst_left = 0;
	bit      hold_req = 1'b0;

	conv2x2_same_end_pad dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_bus),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int sample_addr(int ic, int r, int c);
		return (ic * DEF_MAX_HEIGHT + r) * DEF_MAX_WIDTH + c;
	endfunction

	function automatic int weight_addr(int oc, int ic, int k);
		return (oc * DEF_MAX_IN_CH + ic) * 4 + k;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [31:0] v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// apply one accepted transaction to the shadow state; returns 1 with the element
	function automatic bit predict_conv(input item_t it, output result_t res);
		longint acc;
		int r;
		int c;
		bit produced;
		res = '0;
		produced = 1'b0;
		case (it.func)
		FUNC_WEIGHT: begin
			if (it.channel < eff_out && it.in_channel < eff_in) begin
				weight_mem[weight_addr(it.channel, it.in_channel, it.tap)] = clip16(it.value);
				weight_set[weight_addr(it.channel, it.in_channel, it.tap)] = 1'b1;
			end
		end
		FUNC_BIAS: begin
			if (it.channel < eff_out) begin
				bias_mem[it.channel] = it.value;
				bias_set[it.channel] = 1'b1;
			end
		end
		FUNC_SAMPLE: begin
			if (it.channel < eff_in && it.row < eff_rows && it.col < eff_cols) begin
				sample_mem[sample_addr(it.channel, it.row, it.col)] = clip16(it.value);
				sample_set[sample_addr(it.channel, it.row, it.col)] = 1'b1;
			end
		end
		default: begin
			produced = 1'b1;
			if (it.channel >= eff_out || it.row >= eff_rows || it.col >= eff_cols) begin
				res.status = 1'b1;
			end else begin
				acc = bias_on ? longint'(bias_mem[it.channel]) : 64'sd0;
				for (int ic = 0; ic < eff_in; ic++) begin
					for (int k = 0; k < 4; k++) begin
						r = it.row + (k >> 1);
						c = it.col + (k & 1);
						// taps past the bottom row or right column fall on padding
						if (r < eff_rows && c < eff_cols) begin
							acc += longint'(sample_mem[sample_addr(ic, r, c)]) *
								longint'(weight_mem[weight_addr(it.channel, ic, k)]);
						end
					end
				end
				if (acc > RES_HI) begin
					acc = RES_HI;
				end
				if (acc < RES_LO) begin
					acc = RES_LO;
				end
				res.conv_result = acc[RES_W-1:0];
			end
		end
		endcase
		return produced;
	endfunction

	function automatic item_t make_item(func_t f, logic [3:0] ch, logic [3:0] ich,
		logic [1:0] tap, logic [4:0] row, logic [4:0] col, logic signed [31:0] v);
		item_t it;
		it.func       = f;
		it.channel    = ch;
		it.in_channel = ich;
		it.tap        = tap;
		it.row        = row;
		it.col        = col;
		it.value      = v;
		return it;
	endfunction

	// values weighted towards the 16-bit edges and the 32-bit extremes
	function automatic logic signed [31:0] rand_value();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 4))
		0: return r;
		1: return $signed({{16{r[15]}}, r[15:0]});
		2: return $signed({{24{r[7]}}, r[7:0]});
		3: begin
			case (r[2:0])
			3'd0: return 32'sh7FFF_FFFF;
			3'd1: return 32'sh8000_0000;
			3'd2: return 32'sd32767;
			3'd3: return -32'sd32768;
			3'd4: return 32'sd32768;
			3'd5: return -32'sd32769;
			3'd6: return 32'sd0;
			default: return -32'sd1;
			endcase
		end
		default: return $signed({{12{r[19]}}, r[19:0]});
		endcase
	endfunction

	// index below a configured size, or anything when the size is zero
	function automatic logic [4:0] pick(int n);
		if (n > 0) begin
			return 5'($urandom_range(0, n - 1));
		end
		return 5'($urandom_range(0, 31));
	endfunction

	// drive one transaction in bursts with random gaps and wait for its handshake
	task automatic send_item(input item_t it);
		int gap;
		result_t res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		item_valid <= 1'b1;
		item_bus   <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (predict_conv(it, res)) begin
			expected_elements.push_back(res);
		end
	endtask

	// write every store entry an in-range compute would read but nobody has written yet
	task automatic fill_missing(input item_t req);
		int r;
		int c;
		if (req.channel >= eff_out || req.row >= eff_rows || req.col >= eff_cols) begin
			return;
		end
		if (bias_on && !bias_set[req.channel]) begin
			send_item(make_item(FUNC_BIAS, req.channel, 4'd0, 2'd0, 5'd0, 5'd0, rand_value()));
		end
		for (int ic = 0; ic < eff_in; ic++) begin
			for (int k = 0; k < 4; k++) begin
				r = req.row + (k >> 1);
				c = req.col + (k & 1);
				if (r < eff_rows && c < eff_cols) begin
					if (!weight_set[weight_addr(req.channel, ic, k)]) begin
						send_item(make_item(FUNC_WEIGHT, req.channel, 4'(ic), 2'(k), 5'd0, 5'd0,
							rand_value()));
					end
					if (!sample_set[sample_addr(ic, r, c)]) begin
						send_item(make_item(FUNC_SAMPLE, 4'(ic), 4'd0, 2'd0, 5'(r), 5'(c),
							rand_value()));
					end
				end
			end
		end
	endtask

	task automatic issue(input item_t it);
		if (it.func == FUNC_COMPUTE) begin
			fill_missing(it);
		end
		send_item(it);
	endtask

	// stop sending until every element is back and the block has gone quiet
	task automatic wait_drain();
		item_valid <= 1'b0;
		while (expected_elements.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input int rows, input int cols, input int ich, input int och,
		input int bon);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEIGHT;
		cfg_data  <= CFG_DATA_W'(rows);
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data  <= CFG_DATA_W'(cols);
		@(posedge clk);
		cfg_index <= REG_IN_CH;
		cfg_data  <= CFG_DATA_W'(ich);
		@(posedge clk);
		cfg_index <= REG_OUT_CH;
		cfg_data  <= CFG_DATA_W'(och);
		@(posedge clk);
		cfg_index <= REG_BIAS_EN;
		cfg_data  <= CFG_DATA_W'(bon);
		@(posedge clk);
		cfg_we <= 1'b0;
		img_rows   = 6'(rows);
		img_cols   = 6'(cols);
		in_planes  = 5'(ich);
		out_planes = 5'(och);
		bias_on    = 1'(bon);
		// sizes above the store dimensions act as the maximum
		eff_rows = (img_rows > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : img_rows;
		eff_cols = (img_cols > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : img_cols;
		eff_in   = (in_planes > DEF_MAX_IN_CH) ? DEF_MAX_IN_CH : in_planes;
		eff_out  = (out_planes > DEF_MAX_OUT_CH) ? DEF_MAX_OUT_CH : out_planes;
	endtask

	// mostly in-range computes and writes, the rest fully random transactions
	task automatic random_item();
		item_t it;
		logic [63:0] raw;
		int sel;
		raw = {$urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		it.value = rand_value();
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			it.func    = FUNC_COMPUTE;
			it.channel = pick(eff_out);
			it.row     = pick(eff_rows);
			it.col     = pick(eff_cols);
		end else if (sel < 85) begin
			it.func = func_t'($urandom_range(0, 2));
			case (it.func)
			FUNC_WEIGHT: begin
				it.channel    = pick(eff_out);
				it.in_channel = pick(eff_in);
			end
			FUNC_BIAS: begin
				it.channel = pick(eff_out);
			end
			default: begin
				it.channel = pick(eff_in);
				it.row     = pick(eff_rows);
				it.col     = pick(eff_cols);
			end
			endcase
		end
		issue(it);
	endtask

	task automatic run_phase(input int rows, input int cols, input int ich, input int och,
		input int bon, input int count);
		wait_drain();
		write_regs(rows, cols, ich, och, bon);
		repeat (count) random_item();
	endtask

	// saturating writes, every operation, padding taps and out-of-range cases on a 2x2 image
	task automatic test_directed_ops();
		wait_drain();
		write_regs(2, 2, 1, 2, 1);
		issue(make_item(FUNC_BIAS, 4'd0, 4'd0, 2'd0, 5'd0, 5'd0, 32'sh7FFF_FFFF));
		issue(make_item(FUNC_BIAS, 4'd1, 4'd0, 2'd0, 5'd0, 5'd0, 32'sh8000_0000));
		issue(make_item(FUNC_WEIGHT, 4'd0, 4'd0, 2'd0, 5'd0, 5'd0, 32'sh7FFF_FFFF));
		issue(make_item(FUNC_WEIGHT, 4'd0, 4'd0, 2'd1, 5'd0, 5'd0, 32'sh8000_0000));
		issue(make_item(FUNC_WEIGHT, 4'd0, 4'd0, 2'd2, 5'd0, 5'd0, 32'sd32768));
		issue(make_item(FUNC_WEIGHT, 4'd0, 4'd0, 2'd3, 5'd0, 5'd0, -32'sd32769));
		issue(make_item(FUNC_WEIGHT, 4'd1, 4'd0, 2'd0, 5'd0, 5'd0, -32'sd1));
		issue(make_item(FUNC_WEIGHT, 4'd1, 4'd0, 2'd1, 5'd0, 5'd0, 32'sd1));
		issue(make_item(FUNC_WEIGHT, 4'd1, 4'd0, 2'd2, 5'd0, 5'd0, 32'sd4096));
		issue(make_item(FUNC_WEIGHT, 4'd1, 4'd0, 2'd3, 5'd0, 5'd0, -32'sd4096));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd32767));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd0, 5'd1, -32'sd32768));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd1, 5'd0, 32'sh7FFF_FFFF));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd1, 5'd1, 32'sh8000_0000));
		// writes outside the configured planes or image must leave the stores alone
		issue(make_item(FUNC_WEIGHT, 4'd15, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd123));
		issue(make_item(FUNC_WEIGHT, 4'd0, 4'd15, 2'd3, 5'd0, 5'd0, 32'sd123));
		issue(make_item(FUNC_BIAS, 4'd15, 4'd15, 2'd3, 5'd31, 5'd31, 32'sd123));
		issue(make_item(FUNC_SAMPLE, 4'd15, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd123));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd31, 5'd0, 32'sd123));
		issue(make_item(FUNC_SAMPLE, 4'd0, 4'd0, 2'd0, 5'd0, 5'd31, 32'sd123));
		// full kernel, right edge, bottom edge, corner
		issue(make_item(FUNC_COMPUTE, 4'd0, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd0));
		issue(make_item(FUNC_COMPUTE, 4'd0, 4'd15, 2'd3, 5'd0, 5'd1, 32'sh7FFF_FFFF));
		issue(make_item(FUNC_COMPUTE, 4'd0, 4'd0, 2'd0, 5'd1, 5'd0, 32'sd0));
		issue(make_item(FUNC_COMPUTE, 4'd1, 4'd0, 2'd0, 5'd1, 5'd1, 32'sd0));
		issue(make_item(FUNC_COMPUTE, 4'd1, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd0));
		// bad channel, row and column give status only
		issue(make_item(FUNC_COMPUTE, 4'd15, 4'd0, 2'd0, 5'd0, 5'd0, 32'sd0));
		issue(make_item(FUNC_COMPUTE, 4'd0, 4'd0, 2'd0, 5'd31, 5'd0, 32'sd0));
		issue(make_item(FUNC_COMPUTE, 4'd0, 4'd0, 2'd0, 5'd0, 5'd31, 32'sd0));
	endtask

	// zero and oversized register values, bias off, degenerate image shapes
	task automatic test_register_limits();
		run_phase(0, 32, 16, 16, 1, 12);
		run_phase(32, 0, 16, 16, 1, 12);
		run_phase(63, 63, 31, 31, 0, 12);
		run_phase(4, 4, 0, 3, 1, 15);
		run_phase(4, 4, 2, 0, 1, 15);
		run_phase(1, 1, 1, 1, 1, 15);
		run_phase(1, 32, 16, 1, 1, 12);
		run_phase(32, 1, 1, 16, 0, 12);
	endtask

	task automatic test_random_sizes();
		repeat (14) begin
			run_phase($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 4),
				$urandom_range(1, 4), $urandom_range(0, 1), 50);
		end
		run_phase(32, 32, 2, 3, $urandom_range(0, 1), 100);
		run_phase(3, 3, 16, 16, 1, 100);
	endtask

	// receiver holds off long enough for the input side to back up
	task automatic test_output_stall();
		wait_drain();
		write_regs(3, 3, 2, 2, 1);
		hold_req = 1'b1;
		repeat (40) random_item();
	endtask

	// result receiver: changing stall patterns plus one long hold-off on request
	initial begin : ready_gen
		int mode;
		int mode_left;
		int stall_left;
		bit rdy;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 7) != 0);
				default: begin
					if (stall_left != 0) begin
						rdy = 1'b0;
						stall_left--;
					end else begin
						rdy = 1'b1;
						if ($urandom_range(0, 9) == 0) begin
							stall_left = $urandom_range(1, 24);
						end
					end
				end
				endcase
				result_ready <= rdy;
			end
		end
	end

	// compare each returned element with the oldest prediction
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (expected_elements.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected element, expected none, got conv_result %0d status %0b",
					$time, result_bus.conv_result, result_bus.status);
			end else begin
				exp_element = expected_elements.pop_front();
				if (result_bus.conv_result !== exp_element.conv_result) begin
					mismatch_count++;
					$display("%0t: conv_result mismatch, expected %0d, got %0d", $time,
						exp_element.conv_result, result_bus.conv_result);
				end
				if (result_bus.status !== exp_element.status) begin
					mismatch_count++;
					$display("%0t: status mismatch, expected %0b, got %0b", $time,
						exp_element.status, result_bus.status);
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_register_limits();
		test_random_sizes();
		test_output_stall();
		wait_drain();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/conv2x2_pkg.sv
design/conv2x2_ctrl.sv
design/conv2x2_dp.sv
design/conv2x2_same_end_pad.sv
tb/sv/conv2x2_same_end_pad_test.sv
